// ----- hdl/lpl_pkg.sv -----
package lpl_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 11;

    // result handed from the scan engine to the output register
    typedef struct packed {
        logic [LEN_W-1:0] longest_length;
        logic             overflow;
    } t_result;

endpackage

// ----- hdl/lpl_if.sv -----
interface lpl_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpl_pkg::CHAR_W-1:0] char_byte;
    logic                      is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface lpl_out_if;
    logic                     valid;
    logic                     ready;
    logic [lpl_pkg::LEN_W-1:0] longest_length;
    logic                     overflow;

    modport source (output valid, output longest_length, output overflow, input ready);
    modport sink   (input valid, input longest_length, input overflow, output ready);
endinterface

// ----- hdl/lpl_core.sv -----
module lpl_core #(
    parameter int MAX_LEN = lpl_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lpl_pkg::CHAR_W-1:0]  i_char_byte,
    input  logic                        i_is_last,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output lpl_pkg::t_result            o_res
);
    import lpl_pkg::*;

    localparam int RD = 2 * MAX_LEN + 3;          // radius store depth
    localparam int PW = $clog2(RD);               // transformed position width
    localparam int CW = $clog2(MAX_LEN + 1);      // byte count width
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MIR  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [CHAR_W-1:0] mem_char [MAX_LEN];
    logic [PW-1:0]     mem_rad  [RD];

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf,   n_ovf;
    logic [PW-1:0]     r_total, n_total;
    logic [PW-1:0]     r_i,     n_i;
    logic [PW-1:0]     r_r,     n_r;
    logic [PW-1:0]     r_edge,  n_edge;
    logic [PW-1:0]     r_ctr,   n_ctr;
    logic [PW-1:0]     r_best,  n_best;

    logic [PW-1:0]     r_rad_q;
    logic [CHAR_W-1:0] r_cha_q, r_chb_q;

    logic              in_beat;
    logic              store_ok;
    logic [CW-1:0]     count_after;
    logic              rad_rd;
    logic [PW-1:0]     rad_rd_addr;
    logic              ch_rd;
    logic [PW-1:0]     pos_a, pos_b;
    logic [PW:0]       sum_ir;
    logic              exp_ok;
    logic [PW-1:0]     span;
    logic [PW-1:0]     mirror;
    logic [PW-1:0]     init_r;
    logic [PW+LEN_W-1:0] len_ext;

    assign o_in_ready  = (r_state == S_LOAD);
    assign in_beat     = i_in_valid && o_in_ready;
    assign store_ok    = (32'(r_count) < MAX_LEN);
    assign count_after = store_ok ? r_count + CW'(1) : r_count;

    assign mirror      = PW'({r_ctr, 1'b0} - {1'b0, r_i});
    assign span        = r_edge - r_i;
    assign init_r      = (r_rad_q == '0) ? PW'(1) : ((r_rad_q < span) ? r_rad_q : span);
    assign sum_ir      = {1'b0, r_i} + {1'b0, r_r};
    assign exp_ok      = (r_r <= r_i) && (sum_ir < {1'b0, r_total});
    assign pos_a       = r_i - r_r;
    assign pos_b       = sum_ir[PW-1:0];

    assign rad_rd      = (r_state == S_MIR) && (r_edge > r_i);
    assign rad_rd_addr = mirror;
    // odd positions carry bytes; separators always match
    assign ch_rd       = (r_state == S_EXP) && exp_ok && (r_i[0] ^ r_r[0]);

    assign len_ext     = {{LEN_W{1'b0}}, r_best - PW'(1)};
    assign o_res_valid = (r_state == S_FIN);
    assign o_res.longest_length = len_ext[LEN_W-1:0];
    assign o_res.overflow       = r_ovf;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_total = r_total;
        n_i     = r_i;
        n_r     = r_r;
        n_edge  = r_edge;
        n_ctr   = r_ctr;
        n_best  = r_best;
        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    n_count = count_after;
                    if (!store_ok) begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_total = PW'({count_after, 1'b1});
                        n_i     = '0;
                        n_edge  = '0;
                        n_ctr   = '0;
                        n_best  = '0;
                        n_state = S_MIR;
                    end
                end
            end
            S_MIR: begin
                if (r_edge > r_i) begin
                    n_state = S_INIT;
                end else begin
                    n_r     = PW'(1);
                    n_state = S_EXP;
                end
            end
            S_INIT: begin
                n_r     = init_r;
                n_state = S_EXP;
            end
            S_EXP: begin
                if (!exp_ok) begin
                    n_state = S_WR;
                end else if (ch_rd) begin
                    n_state = S_CMP;
                end else begin
                    n_r = r_r + PW'(1);
                end
            end
            S_CMP: begin
                if (r_cha_q == r_chb_q) begin
                    n_r     = r_r + PW'(1);
                    n_state = S_EXP;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (sum_ir > {1'b0, r_edge}) begin
                    n_edge = sum_ir[PW-1:0];
                    n_ctr  = r_i;
                end
                if (r_r > r_best) begin
                    n_best = r_r;
                end
                if (r_i == r_total - PW'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = S_MIR;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_edge  = '0;
                    n_ctr   = '0;
                    n_best  = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_edge  <= '0;
            r_ctr   <= '0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_edge  <= n_edge;
            r_ctr   <= n_ctr;
            r_best  <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_i     <= n_i;
        r_r     <= n_r;
    end

    // byte store: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (in_beat && store_ok) begin
            mem_char[r_count[AW-1:0]] <= i_char_byte;
        end
        if (ch_rd) begin
            r_cha_q <= mem_char[pos_a[AW:1]];
            r_chb_q <= mem_char[pos_b[AW:1]];
        end
    end

    // radius store: mirror read, write-back of the finished radius
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem_rad[r_i] <= r_r;
        end
        if (rad_rd) begin
            r_rad_q <= mem_rad[rad_rd_addr];
        end
    end

`ifndef SYNTH
    a_no_load_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_in_ready)
        else $error("input taken while result pending");
    a_radius_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_r != '0))
        else $error("zero radius written back");
    a_radius_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (sum_ir <= {1'b0, r_total}) && (r_r <= r_i + PW'(1)))
        else $error("radius runs past the string");
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_count == '0) && !r_ovf && (r_best == '0))
        else $error("string state not cleared after result beat");
    a_mirror_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rad_rd |-> (mirror < r_i))
        else $error("mirror read not behind current position");
`endif

endmodule

// ----- hdl/longest_palindrome_length.sv -----
// Longest palindromic substring length over a byte string.
// Load: one byte beat per cycle; the last beat starts the scan, input waits for the result.
// Scan, per transformed position (2L+1 of them): a mirror check and a write-back, a fetch
// of the mirror radius inside the right edge, a step per separator, a read and a compare
// per byte, a final step when expansion stops at an end; then the result is offered.
// Reset (synchronous, active low) clears control state; the stores are left as they are.
module longest_palindrome_length #(
    parameter int MAX_LEN = lpl_pkg::MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpl_in_if.sink    i_in,
    lpl_out_if.source o_out
);
    import lpl_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    lpl_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_char_byte (i_in.char_byte),
        .i_is_last   (i_in.is_last),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.longest_length = r_out.longest_length;
    assign o_out.overflow       = r_out.overflow;

endmodule
